// ===== rtl/core/cat_pkg.sv =====
// Shared types and constants for the command acknowledgment tracker.
`timescale 1ns / 1ps

package cat_pkg;

    localparam int unsigned CFG_AW     = 3;
    localparam int unsigned CFG_DW     = 32;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned SEQ_W      = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [CODE_W-1:0]    NONE_RESET    = 8'd0;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    // Whole seconds from milliseconds: x / 1000 == (x * 67109) >> 26 for 16-bit x.
    localparam int unsigned           SEC_PROD_W = 33;
    localparam logic [16:0]           SEC_RECIP  = 17'd67109;
    localparam int unsigned           SEC_SHIFT  = 26;

    typedef enum logic [0:0] {
        REG_TIMEOUT_MS = 1'b0,
        REG_NONE_CODE  = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_SET   = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_PENDING = 2'd0,
        STATUS_SUCCESS = 2'd1,
        STATUS_FAILURE = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_ACK  = 2'd1,
        SEND_NACK = 2'd2,
        SEND_RSVD = 2'd3
    } t_send;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CODE_W-1:0] new_command;
        logic [SEQ_W-1:0]  remote_seq;
        logic [1:0]        remote_status;
    } t_in_payload;

    typedef struct packed {
        logic [1:0]        send_kind;
        logic              ack_success;
        logic              set_rejected;
        logic [CODE_W-1:0] current_command;
        logic [SEQ_W-1:0]  current_seq;
        logic [7:0]        seconds_left;
    } t_out_payload;

    // Result as it leaves the tracker core: milliseconds left instead of seconds.
    typedef struct packed {
        logic [1:0]           send_kind;
        logic                 ack_success;
        logic                 set_rejected;
        logic [CODE_W-1:0]    current_command;
        logic [SEQ_W-1:0]     current_seq;
        logic [TIMEOUT_W-1:0] ms_left;
    } t_result;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [CODE_W-1:0]    none_code;
    } t_cfg;

endpackage

// ===== rtl/core/command_ack_tracker.sv =====
// Top level of the stop-and-wait command acknowledgment tracker.
// A result is written into the result buffer when its input transfer is accepted.
// Throughput: one input transfer per cycle; a two-entry result buffer keeps input
// open while one finished result waits, so input stalls only when both entries are full.
// Reset: synchronous, active low; the tracker is idle with sequence and command zero,
// the timeout is 5000 ms, the none code is zero and the result buffer is empty.
`timescale 1ns / 1ps

module command_ack_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cat_pkg::t_in_payload       i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cat_pkg::t_out_payload      o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cat_pkg::CFG_AW-1:0] paddr,
    input  logic [cat_pkg::CFG_DW-1:0] pwdata,
    output logic [cat_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    cat_pkg::t_cfg    cfg;
    cat_pkg::t_result result;
    logic             accept;
    logic             full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    cat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cat_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    cat_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (result),
        .o_full   (full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule

// ===== rtl/core/cat_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module cat_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cat_pkg::CFG_AW-1:0] paddr,
    input  logic [cat_pkg::CFG_DW-1:0] pwdata,
    output logic [cat_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output cat_pkg::t_cfg              o_cfg
);

    logic [cat_pkg::TIMEOUT_W-1:0] r_timeout_ms;
    logic [cat_pkg::CODE_W-1:0]    r_none_code;
    logic                          wr_en;
    cat_pkg::t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cat_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= cat_pkg::TIMEOUT_RESET;
            r_none_code  <= cat_pkg::NONE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                cat_pkg::REG_TIMEOUT_MS: r_timeout_ms <= pwdata[cat_pkg::TIMEOUT_W-1:0];
                cat_pkg::REG_NONE_CODE:  r_none_code  <= pwdata[cat_pkg::CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cat_pkg::REG_TIMEOUT_MS: prdata = {16'd0, r_timeout_ms};
            cat_pkg::REG_NONE_CODE:  prdata = {24'd0, r_none_code};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.timeout_ms = r_timeout_ms;
    assign o_cfg.none_code  = r_none_code;

endmodule

// ===== rtl/core/cat_core.sv =====
// Tracker state and the combinational update for one accepted item.
`timescale 1ns / 1ps

module cat_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  cat_pkg::t_in_payload i_item,
    input  cat_pkg::t_cfg        i_cfg,
    output cat_pkg::t_result     o_result
);

    logic [cat_pkg::CODE_W-1:0]    r_held;
    logic [cat_pkg::SEQ_W-1:0]     r_seq;
    logic                          r_active;
    logic [cat_pkg::TIMEOUT_W-1:0] r_elapsed;
    logic [cat_pkg::SEQ_W-1:0]     r_last_rseq;

    logic [cat_pkg::CODE_W-1:0]    n_held;
    logic [cat_pkg::SEQ_W-1:0]     n_seq;
    logic                          n_active;
    logic [cat_pkg::TIMEOUT_W-1:0] n_elapsed;
    logic [cat_pkg::SEQ_W-1:0]     n_last_rseq;

    logic [cat_pkg::TIMEOUT_W-1:0] tick_elapsed;
    cat_pkg::t_kind                kind;
    cat_pkg::t_status              status;
    cat_pkg::t_send                send;
    logic                          success;
    logic                          rejected;

    assign kind         = cat_pkg::t_kind'(i_item.cmd);
    assign status       = cat_pkg::t_status'(i_item.remote_status);
    assign tick_elapsed = (r_elapsed == cat_pkg::ELAPSED_MAX) ? r_elapsed
                                                              : r_elapsed + 16'd1;

    always_comb begin
        n_held      = r_held;
        n_seq       = r_seq;
        n_active    = r_active;
        n_elapsed   = r_elapsed;
        n_last_rseq = r_last_rseq;
        send        = cat_pkg::SEND_NONE;
        success     = 1'b0;
        rejected    = 1'b0;
        unique case (kind)
            cat_pkg::KIND_SET: begin
                if (r_active) begin
                    rejected = 1'b1;
                end else begin
                    n_held    = i_item.new_command;
                    n_seq     = r_seq + 8'd1;
                    n_elapsed = '0;
                    n_active  = 1'b1;
                end
            end
            cat_pkg::KIND_FRAME: begin
                n_last_rseq = i_item.remote_seq;
                if (r_active && i_item.remote_seq == r_seq) begin
                    if (status == cat_pkg::STATUS_PENDING) begin
                        n_held = i_cfg.none_code;
                    end else begin
                        send      = cat_pkg::SEND_ACK;
                        success   = (status == cat_pkg::STATUS_SUCCESS);
                        n_held    = i_cfg.none_code;
                        n_active  = 1'b0;
                        n_elapsed = '0;
                    end
                end else if (!r_active && i_item.remote_seq != r_seq) begin
                    send      = cat_pkg::SEND_NACK;
                    n_seq     = i_item.remote_seq;
                    n_held    = i_cfg.none_code;
                    n_active  = 1'b0;
                    n_elapsed = '0;
                end
            end
            cat_pkg::KIND_TICK: begin
                if (r_active) begin
                    n_elapsed = tick_elapsed;
                    if (tick_elapsed >= i_cfg.timeout_ms) begin
                        send      = cat_pkg::SEND_NACK;
                        n_seq     = r_last_rseq;
                        n_held    = i_cfg.none_code;
                        n_active  = 1'b0;
                        n_elapsed = '0;
                    end
                end
            end
            cat_pkg::KIND_UNUSED: ;
            default: ;
        endcase
    end

    always_comb begin
        o_result.send_kind       = send;
        o_result.ack_success     = success;
        o_result.set_rejected    = rejected;
        o_result.current_command = n_held;
        o_result.current_seq     = n_seq;
        if (n_active && n_elapsed < i_cfg.timeout_ms) begin
            o_result.ms_left = i_cfg.timeout_ms - n_elapsed;
        end else begin
            o_result.ms_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_seq       <= '0;
            r_active    <= 1'b0;
            r_elapsed   <= '0;
            r_last_rseq <= '0;
        end else if (i_accept) begin
            r_held      <= n_held;
            r_seq       <= n_seq;
            r_active    <= n_active;
            r_elapsed   <= n_elapsed;
            r_last_rseq <= n_last_rseq;
        end
    end

    a_set_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && kind == cat_pkg::KIND_SET && !r_active
        |=> r_active && r_seq == $past(r_seq) + 8'd1 && r_elapsed == '0)
        else $error("set transfer did not start a command");

    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_elapsed == '0)
        else $error("timer running while idle");

    a_send_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && send != cat_pkg::SEND_NONE |=> !r_active)
        else $error("tracker still active after sending a frame");

endmodule

// ===== rtl/core/cat_outbuf.sv =====
// Two-entry result buffer with the milliseconds-to-seconds conversion at its head.
`timescale 1ns / 1ps

module cat_outbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  cat_pkg::t_result      i_result,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_stall,
    output cat_pkg::t_out_payload o_data
);

    cat_pkg::t_result               r_buf [2];
    logic                           r_wr_ptr;
    logic                           r_rd_ptr;
    logic [1:0]                     r_count;
    logic                           pop;
    cat_pkg::t_result               head;
    logic [cat_pkg::SEC_PROD_W-1:0] sec_prod;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign head    = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign sec_prod = {17'd0, head.ms_left} * {16'd0, cat_pkg::SEC_RECIP};

    always_comb begin
        o_data.send_kind       = head.send_kind;
        o_data.ack_success     = head.ack_success;
        o_data.set_rejected    = head.set_rejected;
        o_data.current_command = head.current_command;
        o_data.current_seq     = head.current_seq;
        o_data.seconds_left    = {1'b0, sec_prod[cat_pkg::SEC_PROD_W-1:cat_pkg::SEC_SHIFT]};
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != 2'd2)
        else $error("transfer pushed into a full result buffer");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr ^ r_rd_ptr) == r_count[0] && r_count != 2'd3)
        else $error("result buffer pointers disagree with fill count");

endmodule
